>>> hdl/rau_pkg.sv
// Shared types, constants and helpers for the rational arithmetic unit.
package rau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int WORK_W     = 2 * DATA_WIDTH;
    localparam int MUL_W      = DATA_WIDTH + 1;
    localparam int CNT_W      = $clog2(WORK_W + 1);

    localparam logic signed [WORK_W-1:0] FIT_MAX = WORK_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [WORK_W-1:0] FIT_MIN = WORK_W'(-(64'sd1 <<< (DATA_WIDTH - 1)));

    typedef enum logic [2:0] {
        K_ADD = 3'd0,
        K_SUB = 3'd1,
        K_MUL = 3'd2,
        K_DIV = 3'd3,
        K_CMP = 3'd4,
        K_RED = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_ZERO = 2'd1,
        STAT_OVF  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ORD_LT = 2'd0,
        ORD_EQ = 2'd1,
        ORD_GT = 2'd2
    } t_order;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD_TEST,
        S_GCD_DIV,
        S_LCM_MUL,
        S_LCM_DIV,
        S_Q1_DIV,
        S_T1_MUL,
        S_Q2_DIV,
        S_T2_MUL,
        S_COMBINE,
        S_PROD_NUM,
        S_PROD_DEN,
        S_RED_NUM,
        S_RED_DEN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic                     start;
        logic signed [WORK_W-1:0] dividend;
        logic signed [WORK_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [WORK_W-1:0] quo;
        logic signed [WORK_W-1:0] rem;
        logic        [WORK_W-1:0] quo_mag;
    } t_div_rsp;

    function automatic logic signed [WORK_W-1:0] sext(input logic [DATA_WIDTH-1:0] v);
        return {{(WORK_W - DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
    endfunction

    function automatic logic fits(input logic signed [WORK_W-1:0] v);
        return (v >= FIT_MIN) && (v <= FIT_MAX);
    endfunction

endpackage

>>> hdl/rau_div.sv
// Radix-2 restoring divider, signed truncating quotient and remainder.
module rau_div
    import rau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_run;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORK_W-1:0] r_rem;
    logic [WORK_W-1:0] r_quo;
    logic [WORK_W-1:0] r_dvs;
    logic              r_neg_q;
    logic              r_neg_r;

    logic [WORK_W-1:0] a_mag;
    logic [WORK_W-1:0] b_mag;
    logic [WORK_W-1:0] shifted;
    logic [WORK_W:0]   diff;

    assign a_mag   = i_req.dividend[WORK_W-1] ? WORK_W'(-i_req.dividend) : i_req.dividend;
    assign b_mag   = i_req.divisor[WORK_W-1]  ? WORK_W'(-i_req.divisor)  : i_req.divisor;
    assign shifted = {r_rem[WORK_W-2:0], r_quo[WORK_W-1]};
    assign diff    = {1'b0, shifted} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run   <= 1'b1;
                r_cnt   <= '0;
                r_rem   <= '0;
                r_quo   <= a_mag;
                r_dvs   <= b_mag;
                r_neg_q <= i_req.dividend[WORK_W-1] ^ i_req.divisor[WORK_W-1];
                r_neg_r <= i_req.dividend[WORK_W-1];
            end else if (r_run) begin
                if (!diff[WORK_W]) begin
                    r_rem <= diff[WORK_W-1:0];
                end else begin
                    r_rem <= shifted;
                end
                r_quo <= {r_quo[WORK_W-2:0], ~diff[WORK_W]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORK_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.quo     = r_neg_q ? WORK_W'(-r_quo) : r_quo;
    assign o_rsp.rem     = r_neg_r ? WORK_W'(-r_rem) : r_rem;
    assign o_rsp.quo_mag = r_quo;

endmodule

>>> hdl/rational_arithmetic_unit.sv
// Rational arithmetic unit: sequencer, shared multiplier and shared divider.
// Invalid code or zero denominator: result straight from idle, busy never raised; otherwise each
// divider use, Euclid test and sequencer step adds to the run, and a reduce over a -1
// denominator takes no divider use at all.
// Throughput: one transaction at a time; busy stays high until o_valid; no output stall.
// Reset: synchronous active-low i_rst_n returns to idle with no result pending.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   i_kind,
    input  logic signed [DATA_WIDTH-1:0] i_num_a,
    input  logic signed [DATA_WIDTH-1:0] i_den_a,
    input  logic signed [DATA_WIDTH-1:0] i_num_b,
    input  logic signed [DATA_WIDTH-1:0] i_den_b,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_res_num,
    output logic signed [DATA_WIDTH-1:0] o_res_den,
    output logic [1:0]                   o_order,
    output logic                         o_was_reduced,
    output logic [1:0]                   o_status
);

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic   r_phase, n_phase;
    logic   r_issued, n_issued;
    logic   r_red, n_red;

    logic signed [WORK_W-1:0] r_n1, n_n1, r_d1, n_d1, r_n2, n_n2, r_d2, n_d2;
    logic signed [WORK_W-1:0] r_x, n_x, r_y, n_y, r_ga, n_ga, r_gb, n_gb;
    logic signed [WORK_W-1:0] r_lcm, n_lcm, r_t1, n_t1;
    logic signed [MUL_W-1:0]  r_q, n_q;

    logic                         r_valid, n_valid;
    logic signed [DATA_WIDTH-1:0] r_res_num, n_res_num, r_res_den, n_res_den;
    logic [1:0]                   r_order, n_order, r_status, n_status;
    logic                         r_was_red, n_was_red;

    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [2*MUL_W-1:0]  mul_p;
    logic signed [WORK_W-1:0]   mul_lo;
    logic signed [WORK_W-1:0]   comb_sum;
    t_div_req                   div_req;
    t_div_rsp                   div_rsp;
    t_kind                      in_kind;
    logic                       div_state;

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign mul_p    = mul_a * mul_b;
    assign mul_lo   = WORK_W'(mul_p);
    assign comb_sum = (r_kind == K_SUB) ? r_t1 - r_x : r_t1 + r_x;
    assign in_kind  = t_kind'(i_kind);

    always_comb begin
        mul_a = MUL_W'(r_d1);
        mul_b = MUL_W'(r_d2);
        case (r_state)
            S_T1_MUL: begin
                mul_a = MUL_W'(r_n1);
                mul_b = r_q;
            end
            S_T2_MUL: begin
                mul_a = MUL_W'(r_n2);
                mul_b = r_q;
            end
            S_PROD_NUM: begin
                mul_a = MUL_W'(r_n1);
                mul_b = (r_kind == K_MUL) ? MUL_W'(r_n2) : MUL_W'(r_d2);
            end
            S_PROD_DEN: begin
                mul_a = (r_kind == K_MUL) ? MUL_W'(r_d1) : MUL_W'(r_n2);
                mul_b = (r_kind == K_MUL) ? MUL_W'(r_d2) : MUL_W'(r_d1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        div_state        = 1'b1;
        div_req.dividend = r_ga;
        div_req.divisor  = r_gb;
        case (r_state)
            S_GCD_DIV: begin
            end
            S_LCM_DIV: begin
                div_req.dividend = r_lcm;
                div_req.divisor  = r_ga;
            end
            S_Q1_DIV: begin
                div_req.dividend = r_lcm;
                div_req.divisor  = r_d1;
            end
            S_Q2_DIV: begin
                div_req.dividend = r_lcm;
                div_req.divisor  = r_d2;
            end
            S_RED_NUM: begin
                div_req.dividend = r_x;
                div_req.divisor  = r_ga;
            end
            S_RED_DEN: begin
                div_req.dividend = r_y;
                div_req.divisor  = r_ga;
            end
            default: begin
                div_state = 1'b0;
            end
        endcase
        div_req.start = div_state && !r_issued;
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_phase   = r_phase;
        n_issued  = r_issued;
        n_red     = r_red;
        n_n1      = r_n1;
        n_d1      = r_d1;
        n_n2      = r_n2;
        n_d2      = r_d2;
        n_x       = r_x;
        n_y       = r_y;
        n_ga      = r_ga;
        n_gb      = r_gb;
        n_lcm     = r_lcm;
        n_t1      = r_t1;
        n_q       = r_q;
        n_valid   = 1'b0;
        n_res_num = '0;
        n_res_den = '0;
        n_order   = ORD_LT;
        n_status  = STAT_OK;
        n_was_red = 1'b0;

        if (div_req.start) begin
            n_issued = 1'b1;
        end
        if (div_rsp.done) begin
            n_issued = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind  = in_kind;
                    n_n1    = sext(i_num_a);
                    n_d1    = sext(i_den_a);
                    n_n2    = sext(i_num_b);
                    n_d2    = sext(i_den_b);
                    n_red   = 1'b0;
                    if (i_kind > K_RED) begin
                        n_valid = 1'b1;
                    end else if ((i_den_a == '0)
                            || (i_kind <= K_CMP && i_den_b == '0)
                            || (in_kind == K_DIV && i_num_b == '0)) begin
                        n_valid  = 1'b1;
                        n_status = STAT_ZERO;
                    end else begin
                        case (in_kind)
                            K_ADD, K_SUB, K_CMP: begin
                                n_ga    = sext(i_den_a);
                                n_gb    = sext(i_den_b);
                                n_phase = 1'b0;
                                n_state = S_GCD_TEST;
                            end
                            K_MUL, K_DIV: begin
                                n_state = S_PROD_NUM;
                            end
                            default: begin
                                n_x     = sext(i_num_a);
                                n_y     = sext(i_den_a);
                                n_ga    = sext(i_num_a);
                                n_gb    = sext(i_den_a);
                                n_phase = 1'b1;
                                n_state = S_GCD_TEST;
                            end
                        endcase
                    end
                end
            end
            S_GCD_TEST: begin
                if (r_gb == '0) begin
                    if (!r_phase) begin
                        n_state = S_LCM_MUL;
                    end else if (r_ga > WORK_W'(1)) begin
                        n_state = S_RED_NUM;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else if (r_gb == '1) begin
                    n_ga = r_gb;
                    n_gb = '0;
                end else begin
                    n_state = S_GCD_DIV;
                end
            end
            S_GCD_DIV: begin
                if (div_rsp.done) begin
                    n_ga    = r_gb;
                    n_gb    = div_rsp.rem;
                    n_state = S_GCD_TEST;
                end
            end
            S_LCM_MUL: begin
                n_lcm   = mul_lo;
                n_state = S_LCM_DIV;
            end
            S_LCM_DIV: begin
                if (div_rsp.done) begin
                    n_lcm   = div_rsp.quo_mag;
                    n_state = S_Q1_DIV;
                end
            end
            S_Q1_DIV: begin
                if (div_rsp.done) begin
                    n_q     = MUL_W'(div_rsp.quo);
                    n_state = S_T1_MUL;
                end
            end
            S_T1_MUL: begin
                n_t1    = mul_lo;
                n_state = S_Q2_DIV;
            end
            S_Q2_DIV: begin
                if (div_rsp.done) begin
                    n_q     = MUL_W'(div_rsp.quo);
                    n_state = S_T2_MUL;
                end
            end
            S_T2_MUL: begin
                n_x     = mul_lo;
                n_state = S_COMBINE;
            end
            S_COMBINE: begin
                if (r_kind == K_CMP) begin
                    n_valid = 1'b1;
                    n_order = (r_t1 > r_x) ? ORD_GT : ((r_t1 == r_x) ? ORD_EQ : ORD_LT);
                    n_state = S_IDLE;
                end else begin
                    n_x     = comb_sum;
                    n_y     = r_lcm;
                    n_ga    = comb_sum;
                    n_gb    = r_lcm;
                    n_phase = 1'b1;
                    n_state = S_GCD_TEST;
                end
            end
            S_PROD_NUM: begin
                n_x     = mul_lo;
                n_state = S_PROD_DEN;
            end
            S_PROD_DEN: begin
                n_y     = mul_lo;
                n_ga    = r_x;
                n_gb    = mul_lo;
                n_phase = 1'b1;
                n_state = S_GCD_TEST;
            end
            S_RED_NUM: begin
                if (div_rsp.done) begin
                    n_x     = div_rsp.quo;
                    n_state = S_RED_DEN;
                end
            end
            S_RED_DEN: begin
                if (div_rsp.done) begin
                    n_y     = div_rsp.quo;
                    n_red   = 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_valid = 1'b1;
                if (!fits(r_x) || !fits(r_y)) begin
                    n_status = STAT_OVF;
                end else begin
                    n_res_num = DATA_WIDTH'(r_x);
                    n_res_den = DATA_WIDTH'(r_y);
                    n_was_red = r_red;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_phase   <= n_phase;
        r_red     <= n_red;
        r_n1      <= n_n1;
        r_d1      <= n_d1;
        r_n2      <= n_n2;
        r_d2      <= n_d2;
        r_x       <= n_x;
        r_y       <= n_y;
        r_ga      <= n_ga;
        r_gb      <= n_gb;
        r_lcm     <= n_lcm;
        r_t1      <= n_t1;
        r_q       <= n_q;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_order   <= n_order;
        r_status  <= n_status;
        r_was_red <= n_was_red;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_res_num     = r_res_num;
    assign o_res_den     = r_res_den;
    assign o_order       = r_order;
    assign o_was_reduced = r_was_red;
    assign o_status      = r_status;

endmodule

>>> hdl/rau_checker.sv
// Port-level assertions for the rational arithmetic unit, bound to the top level.
module rau_checker
    import rau_pkg::*;
(
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic signed [DATA_WIDTH-1:0] o_res_num,
    input logic signed [DATA_WIDTH-1:0] o_res_den,
    input logic [1:0]                   o_order,
    input logic                         o_was_reduced,
    input logic [1:0]                   o_status
);

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("accepted transaction neither busy nor done");

    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy || $past(start && !busy))
        else $error("result while still working");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STAT_OK |->
            o_res_num == '0 && o_res_den == '0 && !o_was_reduced && o_order == ORD_LT)
        else $error("error result carries data");

    a_reduced_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_reduced |-> o_status == STAT_OK && o_order == ORD_LT)
        else $error("reduced flag on bad result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_res_num     (o_res_num),
    .o_res_den     (o_res_den),
    .o_order       (o_order),
    .o_was_reduced (o_was_reduced),
    .o_status      (o_status)
);
